// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SSPF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sspf checker: property violated");

// Next-cycle implication, off while reset is high.
`define SSPF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sspf checker: property violated");

// Next-cycle implication that also holds across reset.
`define SSPF_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sspf checker: property violated");

`endif

// ----- rtl/sspf_pkg.sv -----
// Types and constants of the soft-sphere pair force accumulator.
// No dependencies; imported by the interfaces, the divider, the square root, the top level and the checker.
`default_nettype none

package sspf_pkg;

   localparam int CMD_W      = 2;
   localparam int IDX_W      = 10;
   localparam int COORD_W    = 32;
   localparam int FORCE_W    = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_WRITE_POS  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPLY_PAIR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ_FORCE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LENGTH         = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POTENTIAL_STRENGTH = 1'd1;

   localparam logic [CSR_DATA_W-1:0] BOX_LENGTH_RESET = 32'd655360;
   localparam logic [CSR_DATA_W-1:0] STRENGTH_RESET   = 32'd65536;

   localparam logic [1:0] AX_LAST = 2'd2;

   typedef logic [COORD_W-1:0]        coord_type;
   typedef logic signed [FORCE_W-1:0] force_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } pos_vec_type;

   typedef struct packed {
      force_type x;
      force_type y;
      force_type z;
   } force_vec_type;

   typedef struct packed {
      force_type value;
      logic      clipped;
   } clip_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

// ----- rtl/sspf_req_if.sv -----
// Request channel of the pair force accumulator: valid/ready plus command item.
// Depends on sspf_pkg.
`default_nettype none

interface sspf_req_if import sspf_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CMD_W-1:0]       command;
   logic [IDX_W-1:0]       first_index;
   logic [IDX_W-1:0]       second_index;
   logic [COORD_W-1:0]     coord_x;
   logic [COORD_W-1:0]     coord_y;
   logic [COORD_W-1:0]     coord_z;

   modport source (output valid, command, first_index, second_index,
                   coord_x, coord_y, coord_z, input ready);
   modport sink   (input valid, command, first_index, second_index,
                   coord_x, coord_y, coord_z, output ready);
endinterface

`default_nettype wire

// ----- rtl/sspf_rsp_if.sv -----
// Result channel of the pair force accumulator: valid/ready plus result item.
// Depends on sspf_pkg.
`default_nettype none

interface sspf_rsp_if import sspf_pkg::*;;
   logic              valid;
   logic              ready;
   force_type         force_x;
   force_type         force_y;
   force_type         force_z;
   logic              interacted;
   logic              saturated;

   modport source (output valid, force_x, force_y, force_z, interacted, saturated,
                   input ready);
   modport sink   (input valid, force_x, force_y, force_z, interacted, saturated,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/sspf_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module sspf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/sspf_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sspf_pkg for the status struct.
`default_nettype none

module sspf_div import sspf_pkg::*; #(
   parameter int DVD_W = 33,
   parameter int DVS_W = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DVD_W-1:0]     dividend,
   input  logic [DVS_W-1:0]     divisor,
   output unit_status_type      status,
   output logic [DVD_W-1:0]     quotient,
   output logic [DVS_W-1:0]     remainder
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   trial;
   logic             qbit;

   assign shifted = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign qbit    = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in  = CNT_W'(DVD_W - 1);
         busy_in = 1'b1;
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract when it fits
         rem_in = qbit ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], qbit};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = dvd_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/sspf_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on sspf_pkg for the status struct.
`default_nettype none

module sspf_sqrt import sspf_pkg::*; #(
   parameter int IN_W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [IN_W-1:0]       radicand,
   output unit_status_type       status,
   output logic [IN_W/2-1:0]     root
);

   localparam int ROOT_W = IN_W / 2;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [IN_W-1:0]   x_ff, x_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+1:0] rem2;
   logic [ROOT_W+1:0] trial;
   logic              rbit;

   assign rem2  = {rem_ff[ROOT_W-1:0], x_ff[IN_W-1:IN_W-2]};
   assign trial = {root_ff, 2'b01};
   assign rbit  = (rem2 >= trial);

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         cnt_in  = CNT_W'(ROOT_W - 1);
         busy_in = 1'b1;
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = rbit ? (rem2 - trial) : rem2;
         root_in = {root_ff[ROOT_W-2:0], rbit};
         x_in    = {x_ff[IN_W-3:0], 2'b00};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

`default_nettype wire

// ----- rtl/soft_sphere_pair_force_accumulator.sv -----
// Soft-sphere pair force accumulator. Positions (x,y,z) live in one RAM and
// force sums in another, NUM_PARTICLES entries each, both with registered
// reads. One item is in work at a time. Write-position and the unused command
// go straight to the output stage; read-force first reads the force entry. A
// pair item reads both positions, wraps each axis difference with the shared
// restoring divider when the box length is nonzero (DIV_W = max(33,
// 2*FRAC_BITS)), squares and sums, takes the root, divides each axis by the
// root on the same divider and does the read-modify-write of both force
// entries. An out-of-range pair ends after the wrap or the square sum. After
// reset the block sweeps the force RAM to zero, one entry per cycle, and
// accepts no item meanwhile; register writes are taken at any time. A
// finished result sits in the output register while the next item is
// accepted.
// Depends on sspf_pkg, sspf_req_if, sspf_rsp_if, sspf_ram, sspf_div, sspf_sqrt.
`default_nettype none

module soft_sphere_pair_force_accumulator import sspf_pkg::*; #(
   parameter int NUM_PARTICLES = 1024,
   parameter int FRAC_BITS     = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   sspf_req_if.sink              req_chan,
   sspf_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW    = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
   localparam int D_W   = COORD_W + 1;               // wrapped difference
   localparam int V_W   = COORD_W + 2;               // difference plus half box
   localparam int DIV_W = (2 * FRAC_BITS > COORD_W + 1) ? 2 * FRAC_BITS : COORD_W + 1;
   localparam int S_W   = 2 * FRAC_BITS + 2;         // sum of squares
   localparam int G_W   = FRAC_BITS + 3;             // q - d, signed
   localparam int GM_W  = FRAC_BITS + 2;             // |q - d|
   localparam int P_W   = COORD_W + GM_W;            // strength * |g|
   localparam int SC_W  = P_W - FRAC_BITS;           // product scaled back

   localparam logic [AW:0]     NUM_W     = (AW + 1)'(NUM_PARTICLES);
   localparam logic [AW-1:0]   LAST_IDX  = AW'(NUM_PARTICLES - 1);
   localparam logic [SC_W-1:0] NEG_LIMIT = SC_W'(1) << (FORCE_W - 1);

   // sequencer states
   localparam logic [4:0] ST_CLEAR     = 5'd0;
   localparam logic [4:0] ST_IDLE      = 5'd1;
   localparam logic [4:0] ST_FREAD     = 5'd2;
   localparam logic [4:0] ST_POS_A     = 5'd3;
   localparam logic [4:0] ST_POS_B     = 5'd4;
   localparam logic [4:0] ST_WRAP      = 5'd5;
   localparam logic [4:0] ST_WRAP_WAIT = 5'd6;
   localparam logic [4:0] ST_RANGE     = 5'd7;
   localparam logic [4:0] ST_SQUARE    = 5'd8;
   localparam logic [4:0] ST_SCHECK    = 5'd9;
   localparam logic [4:0] ST_SQRT_WAIT = 5'd10;
   localparam logic [4:0] ST_DIV       = 5'd11;
   localparam logic [4:0] ST_DIV_WAIT  = 5'd12;
   localparam logic [4:0] ST_MUL       = 5'd13;
   localparam logic [4:0] ST_SCALE     = 5'd14;
   localparam logic [4:0] ST_ACC_A     = 5'd15;
   localparam logic [4:0] ST_ACC_B     = 5'd16;
   localparam logic [4:0] ST_EMIT      = 5'd17;

   // Reduce a raw index modulo the particle count: one compare-subtract per bit.
   function automatic logic [AW-1:0] idx_mod(input logic [IDX_W-1:0] v);
      logic [AW:0] r;
      r = '0;
      for (int i = IDX_W - 1; i >= 0; i--) begin
         r = {r[AW-1:0], v[i]};
         if (r >= NUM_W) begin
            r = r - NUM_W;
         end
      end
      return r[AW-1:0];
   endfunction

   // Clip a 33-bit sum into the signed 32-bit range.
   function automatic clip_type clip_sum(input logic [FORCE_W:0] v);
      clip_type c;
      c.value   = v[FORCE_W-1:0];
      c.clipped = 1'b0;
      if (v[FORCE_W:FORCE_W-1] == 2'b01) begin
         c.value   = {1'b0, {(FORCE_W-1){1'b1}}};
         c.clipped = 1'b1;
      end else if (v[FORCE_W:FORCE_W-1] == 2'b10) begin
         c.value   = {1'b1, {(FORCE_W-1){1'b0}}};
         c.clipped = 1'b1;
      end
      return c;
   endfunction

   function automatic logic [D_W-1:0] mag_d(input logic [D_W-1:0] d);
      return d[D_W-1] ? (~d + 1'b1) : d;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [4:0]           state_ff, state_in;
   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [CSR_DATA_W-1:0] box_length_ff, box_length_in;
   logic [CSR_DATA_W-1:0] strength_ff, strength_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0]        a_ff, a_in;
   logic [AW-1:0]        b_ff, b_in;
   pos_vec_type          pa_ff, pa_in;
   pos_vec_type          pb_ff, pb_in;
   logic [1:0]           ax_ff, ax_in;
   logic [D_W-1:0]       d_ff [3];
   logic [D_W-1:0]       d_in [3];
   logic                 vneg_ff, vneg_in;
   logic [S_W-1:0]       s_ff, s_in;
   logic [FRAC_BITS-1:0] r_ff, r_in;
   logic [GM_W-1:0]      gmag_ff, gmag_in;
   logic                 gneg_ff, gneg_in;
   logic [P_W-1:0]       prod_ff, prod_in;
   force_type            f_ff [3];
   force_type            f_in [3];
   force_vec_type        res_force_ff, res_force_in;
   logic                 res_inter_ff, res_inter_in;
   logic                 res_sat_ff, res_sat_in;
   force_vec_type        rsp_force_ff, rsp_force_in;
   logic                 rsp_inter_ff, rsp_inter_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   // ---------------------------------------------------------------- memories
   logic          pos_we, pos_re;
   logic [AW-1:0] pos_waddr, pos_raddr;
   pos_vec_type   pos_wdata, pos_rdata;
   logic          frc_we, frc_re;
   logic [AW-1:0] frc_waddr, frc_raddr;
   force_vec_type frc_wdata, frc_rdata;

   sspf_ram #(.WIDTH($bits(pos_vec_type)), .DEPTH(NUM_PARTICLES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (pos_wdata),
      .rd_en   (pos_re),
      .rd_addr (pos_raddr),
      .rd_data (pos_rdata)
   );

   sspf_ram #(.WIDTH($bits(force_vec_type)), .DEPTH(NUM_PARTICLES)) u_frc_ram (
      .clock   (clock),
      .wr_en   (frc_we),
      .wr_addr (frc_waddr),
      .wr_data (frc_wdata),
      .rd_en   (frc_re),
      .rd_addr (frc_raddr),
      .rd_data (frc_rdata)
   );

   // ---------------------------------------------------------------- shared units
   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [COORD_W-1:0] div_divisor;
   unit_status_type  div_stat;
   logic [DIV_W-1:0] div_quot;
   logic [COORD_W-1:0] div_rem;

   sspf_div #(.DVD_W(DIV_W), .DVS_W(COORD_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   logic                 sqrt_start;
   unit_status_type      sqrt_stat;
   logic [FRAC_BITS-1:0] sqrt_root;

   sspf_sqrt #(.IN_W(2 * FRAC_BITS)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (s_ff[2*FRAC_BITS-1:0]),
      .status   (sqrt_stat),
      .root     (sqrt_root)
   );

   // ---------------------------------------------------------------- datapath
   logic               accept;
   logic [AW-1:0]      a_mod, b_mod;
   coord_type          coord_a, coord_b;
   logic [D_W-1:0]     diff;
   logic [COORD_W-1:0] half;
   logic [V_W-1:0]     v_sum, v_abs;
   logic [COORD_W-1:0] t_wrap;
   logic [D_W-1:0]     d_wrap;
   logic [D_W-1:0]     d_cur, dmag_cur;
   logic [FRAC_BITS-1:0] m_cur;
   logic [2*FRAC_BITS-1:0] sq_cur;
   logic               range_ok;
   logic [FRAC_BITS:0] q_mag;
   logic [G_W-1:0]     q_s, d_low, g_val, g_abs;
   logic [P_W-1:0]     prod_full;
   logic [SC_W-1:0]    scaled;
   clip_type           f_clip;
   clip_type           acc_x, acc_y, acc_z;

   assign accept = req_chan.valid && req_chan.ready;
   assign a_mod  = idx_mod(req_chan.first_index);
   assign b_mod  = idx_mod(req_chan.second_index);

   always_comb begin
      case (ax_ff)
         2'd0: begin
            coord_a = pa_ff.x;
            coord_b = pb_ff.x;
         end
         2'd1: begin
            coord_a = pa_ff.y;
            coord_b = pb_ff.y;
         end
         default: begin
            coord_a = pa_ff.z;
            coord_b = pb_ff.z;
         end
      endcase
   end

   // periodic wrap: d = ((d + h) mod L) - h, with a nonnegative mod
   assign diff   = {1'b0, coord_a} - {1'b0, coord_b};
   assign half   = {1'b0, box_length_ff[COORD_W-1:1]};
   assign v_sum  = {diff[D_W-1], diff} + {2'b00, half};
   assign v_abs  = v_sum[V_W-1] ? (~v_sum + 1'b1) : v_sum;
   assign t_wrap = (vneg_ff && (div_rem != '0)) ? (box_length_ff - div_rem) : div_rem;
   assign d_wrap = {1'b0, t_wrap} - {1'b0, half};

   assign d_cur    = d_ff[ax_ff];
   assign dmag_cur = mag_d(d_cur);
   assign m_cur    = dmag_cur[FRAC_BITS-1:0];
   assign sq_cur   = {{FRAC_BITS{1'b0}}, m_cur} * {{FRAC_BITS{1'b0}}, m_cur};

   assign range_ok = (mag_d(d_ff[0]) >> FRAC_BITS) == '0
                  && (mag_d(d_ff[1]) >> FRAC_BITS) == '0
                  && (mag_d(d_ff[2]) >> FRAC_BITS) == '0;

   // g = q - d with q = d*ONE/r truncated toward zero
   assign q_mag  = div_quot[FRAC_BITS:0];
   assign q_s    = d_cur[D_W-1] ? (~{2'b00, q_mag} + 1'b1) : {2'b00, q_mag};
   assign d_low  = {{2{d_cur[D_W-1]}}, d_cur[FRAC_BITS:0]};
   assign g_val  = q_s - d_low;
   assign g_abs  = g_val[G_W-1] ? (~g_val + 1'b1) : g_val;

   assign prod_full = {{(P_W-CSR_DATA_W){1'b0}}, strength_ff}
                    * {{(P_W-GM_W){1'b0}}, gmag_ff};
   assign scaled    = prod_ff[P_W-1:FRAC_BITS];

   always_comb begin
      f_clip.clipped = 1'b0;
      if (!gneg_ff) begin
         if (scaled[SC_W-1:FORCE_W-1] != '0) begin
            f_clip.value   = {1'b0, {(FORCE_W-1){1'b1}}};
            f_clip.clipped = 1'b1;
         end else begin
            f_clip.value = scaled[FORCE_W-1:0];
         end
      end else begin
         if (scaled > NEG_LIMIT) begin
            f_clip.value   = {1'b1, {(FORCE_W-1){1'b0}}};
            f_clip.clipped = 1'b1;
         end else begin
            f_clip.value = ~scaled[FORCE_W-1:0] + 1'b1;
         end
      end
   end

   // ST_ACC_A adds f to the first particle, ST_ACC_B subtracts it from the second
   always_comb begin
      if (state_ff == ST_ACC_A) begin
         acc_x = clip_sum({frc_rdata.x[FORCE_W-1], frc_rdata.x} + {f_ff[0][FORCE_W-1], f_ff[0]});
         acc_y = clip_sum({frc_rdata.y[FORCE_W-1], frc_rdata.y} + {f_ff[1][FORCE_W-1], f_ff[1]});
         acc_z = clip_sum({frc_rdata.z[FORCE_W-1], frc_rdata.z} + {f_ff[2][FORCE_W-1], f_ff[2]});
      end else begin
         acc_x = clip_sum({frc_rdata.x[FORCE_W-1], frc_rdata.x} - {f_ff[0][FORCE_W-1], f_ff[0]});
         acc_y = clip_sum({frc_rdata.y[FORCE_W-1], frc_rdata.y} - {f_ff[1][FORCE_W-1], f_ff[1]});
         acc_z = clip_sum({frc_rdata.z[FORCE_W-1], frc_rdata.z} - {f_ff[2][FORCE_W-1], f_ff[2]});
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      box_length_in = box_length_ff;
      strength_in   = strength_ff;
      rsp_valid_in  = rsp_valid_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      ax_in         = ax_ff;
      d_in          = d_ff;
      vneg_in       = vneg_ff;
      s_in          = s_ff;
      r_in          = r_ff;
      gmag_in       = gmag_ff;
      gneg_in       = gneg_ff;
      prod_in       = prod_ff;
      f_in          = f_ff;
      res_force_in  = res_force_ff;
      res_inter_in  = res_inter_ff;
      res_sat_in    = res_sat_ff;
      rsp_force_in  = rsp_force_ff;
      rsp_inter_in  = rsp_inter_ff;
      rsp_sat_in    = rsp_sat_ff;

      pos_we       = 1'b0;
      pos_waddr    = a_mod;
      pos_wdata    = {req_chan.coord_x, req_chan.coord_y, req_chan.coord_z};
      pos_re       = 1'b0;
      pos_raddr    = a_mod;
      frc_we       = 1'b0;
      frc_waddr    = a_ff;
      frc_wdata    = '0;
      frc_re       = 1'b0;
      frc_raddr    = a_ff;
      div_start    = 1'b0;
      div_dividend = {{(DIV_W-FRAC_BITS-FRAC_BITS){1'b0}}, m_cur, {FRAC_BITS{1'b0}}};
      div_divisor  = {{(COORD_W-FRAC_BITS){1'b0}}, r_ff};
      sqrt_start   = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_BOX_LENGTH:         box_length_in = csr_wdata;
            CSR_POTENTIAL_STRENGTH: strength_in   = csr_wdata;
            default:                ;
         endcase
      end

      // drop the output item once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            frc_we    = 1'b1;
            frc_waddr = clr_cnt_ff;
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               a_in         = a_mod;
               b_in         = b_mod;
               res_force_in = '0;
               res_inter_in = 1'b0;
               res_sat_in   = 1'b0;
               unique case (req_chan.command)
                  CMD_WRITE_POS: begin
                     pos_we   = 1'b1;
                     state_in = ST_EMIT;
                  end
                  CMD_APPLY_PAIR: begin
                     pos_re   = 1'b1;
                     state_in = ST_POS_A;
                  end
                  CMD_READ_FORCE: begin
                     frc_re    = 1'b1;
                     frc_raddr = a_mod;
                     state_in  = ST_FREAD;
                  end
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_FREAD: begin
            res_force_in = frc_rdata;
            frc_we       = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_POS_A: begin
            pa_in     = pos_rdata;
            pos_re    = 1'b1;
            pos_raddr = b_ff;
            state_in  = ST_POS_B;
         end
         ST_POS_B: begin
            pb_in    = pos_rdata;
            ax_in    = 2'd0;
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            if (box_length_ff == '0) begin
               d_in[ax_ff] = diff;
               ax_in       = ax_ff + 1'b1;
               if (ax_ff == AX_LAST) begin
                  state_in = ST_RANGE;
               end
            end else if (!div_stat.busy) begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(v_abs[COORD_W:0]);
               div_divisor  = box_length_ff;
               vneg_in      = v_sum[V_W-1];
               state_in     = ST_WRAP_WAIT;
            end
         end
         ST_WRAP_WAIT: begin
            if (div_stat.done) begin
               d_in[ax_ff] = d_wrap;
               ax_in       = ax_ff + 1'b1;
               state_in    = (ax_ff == AX_LAST) ? ST_RANGE : ST_WRAP;
            end
         end
         ST_RANGE: begin
            s_in  = '0;
            ax_in = 2'd0;
            state_in = range_ok ? ST_SQUARE : ST_EMIT;
         end
         ST_SQUARE: begin
            s_in  = s_ff + {2'b00, sq_cur};
            ax_in = ax_ff + 1'b1;
            if (ax_ff == AX_LAST) begin
               state_in = ST_SCHECK;
            end
         end
         ST_SCHECK: begin
            // in range only for 0 < s < ONE*ONE
            if (s_ff == '0 || s_ff[S_W-1:2*FRAC_BITS] != '0) begin
               state_in = ST_EMIT;
            end else begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT_WAIT;
            end
         end
         ST_SQRT_WAIT: begin
            if (sqrt_stat.done) begin
               r_in     = (sqrt_root == '0) ? FRAC_BITS'(1) : sqrt_root;
               ax_in    = 2'd0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!div_stat.busy) begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               gmag_in  = g_abs[GM_W-1:0];
               gneg_in  = g_val[G_W-1];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = prod_full;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            f_in[ax_ff] = f_clip.value;
            res_sat_in  = res_sat_ff | f_clip.clipped;
            ax_in       = ax_ff + 1'b1;
            if (ax_ff == AX_LAST) begin
               frc_re   = 1'b1;
               state_in = ST_ACC_A;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_ACC_A: begin
            frc_we     = 1'b1;
            frc_wdata  = {acc_x.value, acc_y.value, acc_z.value};
            res_sat_in = res_sat_ff | acc_x.clipped | acc_y.clipped | acc_z.clipped;
            frc_re     = 1'b1;
            frc_raddr  = b_ff;
            state_in   = ST_ACC_B;
         end
         ST_ACC_B: begin
            frc_we       = 1'b1;
            frc_waddr    = b_ff;
            frc_wdata    = {acc_x.value, acc_y.value, acc_z.value};
            res_sat_in   = res_sat_ff | acc_x.clipped | acc_y.clipped | acc_z.clipped;
            res_inter_in = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_force_in = res_force_ff;
               rsp_inter_in = res_inter_ff;
               rsp_sat_in   = res_sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         box_length_ff <= BOX_LENGTH_RESET;
         strength_ff   <= STRENGTH_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         box_length_ff <= box_length_in;
         strength_ff   <= strength_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      ax_ff        <= ax_in;
      d_ff         <= d_in;
      vneg_ff      <= vneg_in;
      s_ff         <= s_in;
      r_ff         <= r_in;
      gmag_ff      <= gmag_in;
      gneg_ff      <= gneg_in;
      prod_ff      <= prod_in;
      f_ff         <= f_in;
      res_force_ff <= res_force_in;
      res_inter_ff <= res_inter_in;
      res_sat_ff   <= res_sat_in;
      rsp_force_ff <= rsp_force_in;
      rsp_inter_ff <= rsp_inter_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   // ---------------------------------------------------------------- ports
   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.force_x    = rsp_force_ff.x;
   assign rsp_chan.force_y    = rsp_force_ff.y;
   assign rsp_chan.force_z    = rsp_force_ff.z;
   assign rsp_chan.interacted = rsp_inter_ff;
   assign rsp_chan.saturated  = rsp_sat_ff;

endmodule

`default_nettype wire

// ----- rtl/sspf_checker.sv -----
// Port-level checker of the pair force accumulator, bound to the top level.
// Depends on sspf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sspf_checker import sspf_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input force_type rsp_force_x,
   input force_type rsp_force_y,
   input force_type rsp_force_z,
   input logic      rsp_interacted,
   input logic      rsp_saturated
);

   logic force_zero;

   assign force_zero = (rsp_force_x == '0) && (rsp_force_y == '0) && (rsp_force_z == '0);

   // a pending item stays offered until taken
   `SSPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // only a pair item can clip, and a clipped pair is always an interacting one
   `SSPF_ASSERT_IMPL(a_sat_needs_pair, clock, reset, rsp_valid && rsp_saturated, rsp_interacted)

   // a pair item carries no force readout
   `SSPF_ASSERT_IMPL(a_pair_no_force, clock, reset, rsp_valid && rsp_interacted, force_zero)

   // reset empties the output register
   `SSPF_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind soft_sphere_pair_force_accumulator sspf_checker u_sspf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_force_x    (rsp_chan.force_x),
   .rsp_force_y    (rsp_chan.force_y),
   .rsp_force_z    (rsp_chan.force_z),
   .rsp_interacted (rsp_chan.interacted),
   .rsp_saturated  (rsp_chan.saturated)
);

`default_nettype wire
